@@ rtl/core/slist_pkg.sv @@
// Package for the sorted list block: opcodes, status codes, FSM states
// and the fixed field widths of the stream payloads.
// No dependencies.
`timescale 1ns / 1ps

package slist_pkg;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_DUMP     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EV,
    S_INS_PUT0,
    S_REM_RD,
    S_REM_EV,
    S_DMP_RD,
    S_DMP_EV
  } state_t;

  // result waiting for the output register
  typedef struct packed {
    logic               pend;
    status_t            status;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

@@ rtl/core/sorted_list_insert_remove_top.sv @@
// Sorted list of signed values with insert, remove and dump over streams.
// Depends on slist_pkg and slist_store.
//
//  channel | dir | tdata (low bit up)                        | tuser        | tlast
//  s_*     | in  | operand_value[31:0]                       | opcode[1:0]  | -
//  m_*     | out | entry_value[31:0], entry_index[35:32],    | status[2:0]  | last_of_run
//          |     | count_after[40:36], zero pad [47:41]      |              |
//
// One item at a time; each step of a scan is a read of the store and an
// evaluation of the read data. Insert shifts the entries not smaller than
// the value up from the tail; into an empty list it writes at once. Remove
// scans from the head and stops at the first larger entry if no equal entry
// came before it, else at the end of the list. Dump emits one entry per step.
// Full, empty and no-op items need no scan. Reset clears the entry count;
// store contents need no clearing. A stalled output holds a dump at its
// emit step and a single result in the pending slot; the input is taken
// again once the item's last result sits in the output register.
`timescale 1ns / 1ps

module sorted_list_insert_remove_top #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // operand_value[31:0]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // entry_value, entry_index, count_after, pad
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast    // last_of_run
);
  import slist_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t             state, state_next;
  logic [AW-1:0]      idx, idx_next;
  logic [AW-1:0]      pos, pos_next;
  logic               found, found_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [VALUE_W-1:0] val, val_next;
  res_t               res, res_next;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               rd_en;
  logic [VALUE_W-1:0] rd_data;

  logic               out_free;
  logic               out_load;
  status_t            out_status;
  logic [VALUE_W-1:0] out_value;
  logic [INDEX_W-1:0] out_index;
  logic [COUNT_W-1:0] out_count;
  logic               out_last;

  logic               s_fire;
  logic               idx_is_last;
  logic               rd_less;
  logic               val_less;

  slist_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  assign out_free    = !m_tvalid || m_tready;
  assign s_tready    = (state == S_IDLE) && !res.pend;
  assign s_fire      = s_tvalid && s_tready;
  assign idx_is_last = (CW'(idx) + CW'(1)) == cnt;
  assign rd_less     = $signed(rd_data) < $signed(val);
  assign val_less    = $signed(val) < $signed(rd_data);

  // next state, store access and result selection
  always_comb begin
    state_next = state;
    idx_next   = idx;
    pos_next   = pos;
    found_next = found;
    cnt_next   = cnt;
    val_next   = val;
    res_next   = res;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = rd_data;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    out_status = res.status;
    out_value  = res.value;
    out_index  = res.index;
    out_count  = res.count;
    out_last   = 1'b1;

    // single results leave through the pending slot
    if (res.pend && out_free) begin
      out_load      = 1'b1;
      res_next.pend = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (s_fire) begin
          val_next   = s_tdata;
          idx_next   = '0;
          found_next = 1'b0;
          case (op_t'(s_tuser))
            OP_INSERT: begin
              if (cnt == CW'(DEPTH)) begin
                res_next = '{1'b1, ST_FULL, s_tdata, '0, COUNT_W'(cnt)};
              end else if (cnt == '0) begin
                wr_en    = 1'b1;
                wr_addr  = '0;
                wr_data  = s_tdata;
                cnt_next = CW'(1);
                res_next = '{1'b1, ST_INSERTED, s_tdata, '0, COUNT_W'(1)};
              end else begin
                idx_next   = AW'(cnt - CW'(1));
                state_next = S_INS_RD;
              end
            end
            OP_REMOVE: begin
              if (cnt == '0) begin
                res_next = '{1'b1, ST_EMPTY, s_tdata, '0, '0};
              end else begin
                state_next = S_REM_RD;
              end
            end
            OP_DUMP: begin
              if (cnt == '0) begin
                res_next = '{1'b1, ST_EMPTY, '0, '0, '0};
              end else begin
                state_next = S_DMP_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_INS_RD: begin
        rd_en      = 1'b1;
        state_next = S_INS_EV;
      end

      // shift entries not smaller than the value up by one, then place the value
      S_INS_EV: begin
        wr_en   = 1'b1;
        wr_addr = idx + AW'(1);
        if (rd_less) begin
          wr_data    = val;
          cnt_next   = cnt + CW'(1);
          res_next   = '{1'b1, ST_INSERTED, val, INDEX_W'(idx + AW'(1)),
                        COUNT_W'(cnt + CW'(1))};
          state_next = S_IDLE;
        end else if (idx == '0) begin
          state_next = S_INS_PUT0;
        end else begin
          idx_next   = idx - AW'(1);
          state_next = S_INS_RD;
        end
      end

      S_INS_PUT0: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = val;
        cnt_next   = cnt + CW'(1);
        res_next   = '{1'b1, ST_INSERTED, val, '0, COUNT_W'(cnt + CW'(1))};
        state_next = S_IDLE;
      end

      S_REM_RD: begin
        rd_en      = 1'b1;
        state_next = S_REM_EV;
      end

      // find the first equal entry, then pull later entries down; stop at a larger entry before a match
      S_REM_EV: begin
        if (found) begin
          wr_en   = 1'b1;
          wr_addr = idx - AW'(1);
        end else if (rd_data == val) begin
          found_next = 1'b1;
          pos_next   = idx;
        end
        if (!found && rd_data != val && val_less) begin
          res_next   = '{1'b1, ST_NOTFOUND, val, '0, COUNT_W'(cnt)};
          state_next = S_IDLE;
        end else if (idx_is_last) begin
          if (found_next) begin
            cnt_next = cnt - CW'(1);
            res_next = '{1'b1, ST_REMOVED, val, INDEX_W'(pos_next),
                        COUNT_W'(cnt - CW'(1))};
          end else begin
            res_next = '{1'b1, ST_NOTFOUND, val, '0, COUNT_W'(cnt)};
          end
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = S_REM_RD;
        end
      end

      S_DMP_RD: begin
        rd_en      = 1'b1;
        state_next = S_DMP_EV;
      end

      // emit one entry when the output register frees up
      S_DMP_EV: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = ST_DUMP;
          out_value  = rd_data;
          out_index  = INDEX_W'(idx);
          out_count  = COUNT_W'(cnt);
          out_last   = idx_is_last;
          if (idx_is_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = S_DMP_RD;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // control registers and the pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      found    <= 1'b0;
      res.pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      found    <= found_next;
      res      <= res_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    pos        <= pos_next;
    val        <= val_next;
    if (out_load) begin
      m_tdata <= {7'd0, out_count, out_index, out_value};
      m_tuser <= out_status;
      m_tlast <= out_last;
    end
  end

  // entry count never passes the list depth
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  // a full report carries the depth as count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[40:36] == COUNT_W'(DEPTH)))
    else $error("full status with wrong count");

  // a dump in progress keeps the input closed
  a_dump_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_DUMP && !m_tlast) |-> !s_tready)
    else $error("input open during dump");

  // a pending insert result reports the current entry count
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (res.pend && res.status == ST_INSERTED) |-> (res.count == COUNT_W'(cnt)))
    else $error("insert count mismatch");

endmodule

@@ rtl/core/slist_store.sv @@
// Entry store for the sorted list: one write port, one read port with
// registered read data.
// Depends on slist_pkg for the value width.
`timescale 1ns / 1ps

module slist_store #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [$clog2(DEPTH)-1:0]             wr_addr,
  input  logic [slist_pkg::VALUE_W-1:0]        wr_data,
  input  logic                                 rd_en,
  input  logic [$clog2(DEPTH)-1:0]             rd_addr,
  output logic [slist_pkg::VALUE_W-1:0]        rd_data
);
  import slist_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
